// ===== design/gclb_pkg.sv =====
// Shared types and constants for the grid cell-list binning block.
// No dependencies; every other file of the block takes names from here.
package gclb_pkg;

  // Grid and point store sizes
  localparam int MAX_SIDE   = 32;
  localparam int MAX_POINTS = 65536;
  localparam int POS_BITS   = 24;
  localparam int NCELLS     = MAX_SIDE * MAX_SIDE * MAX_SIDE;

  // Field and internal widths
  localparam int OP_W    = 3;
  localparam int POS_W   = 24;
  localparam int SCALE_W = 32;
  localparam int PROD_W  = POS_W + SCALE_W;
  localparam int SIDE_W  = 6;
  localparam int AX_W    = 5;
  localparam int IJ_W    = 10;
  localparam int CELL_W  = 15;
  localparam int CNT_W   = 17;
  localparam int ID_W    = 16;
  localparam int SLOT_W  = 16;
  localparam int MADDR_W = 16;
  localparam int ST_W    = 2;
  localparam int CFGI_W  = 2;
  localparam int CFGD_W  = 32;
  localparam int NBR_W   = 5;
  localparam int NBR_LAST = 26;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR       = 3'd0,
    OP_COUNT       = 3'd1,
    OP_PREFIX      = 3'd2,
    OP_PLACE       = 3'd3,
    OP_READ_CELL   = 3'd4,
    OP_READ_MEMBER = 3'd5,
    OP_NEIGHBOUR   = 3'd6,
    OP_UNKNOWN     = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [CFGI_W-1:0] {
    CFG_SIDE    = 2'd0,
    CFG_SCALE_X = 2'd1,
    CFG_SCALE_Y = 2'd2,
    CFG_SCALE_Z = 2'd3
  } cfg_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    clr_step;
    logic    mul;
    logic    sat;
    logic    wrap;
    logic    cell1;
    logic    cell2;
    logic    pfx_rd;
    logic    pfx_wr;
    logic    mem_wb;
    logic    div_start;
    logic    div_pass;
    logic    err_set;
    status_t err_code;
    logic    out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic store_full;
    logic sel_bad;
    logic slot_bad;
    logic sweep_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== design/gclb_if.sv =====
// Word channels of the binning block: input item and result item.
// Depends on gclb_pkg for field widths.
interface gclb_in_if;
  logic                          valid;
  logic                          ready;
  logic [gclb_pkg::OP_W-1:0]     operation;
  logic [gclb_pkg::POS_W-1:0]    pos_x;
  logic [gclb_pkg::POS_W-1:0]    pos_y;
  logic [gclb_pkg::POS_W-1:0]    pos_z;
  logic [gclb_pkg::ID_W-1:0]     point_id;
  logic [gclb_pkg::CELL_W-1:0]   cell_select;
  logic [gclb_pkg::SLOT_W-1:0]   slot;

  modport source (output valid, operation, pos_x, pos_y, pos_z, point_id, cell_select, slot,
                  input ready);
  modport sink   (input valid, operation, pos_x, pos_y, pos_z, point_id, cell_select, slot,
                  output ready);
endinterface

interface gclb_out_if;
  logic                          valid;
  logic                          ready;
  logic [gclb_pkg::CELL_W-1:0]   cell_out;
  logic [gclb_pkg::CNT_W-1:0]    cell_count;
  logic [gclb_pkg::CNT_W-1:0]    cell_start;
  logic [gclb_pkg::ID_W-1:0]     member_out;
  logic [gclb_pkg::ST_W-1:0]     status;

  modport source (output valid, cell_out, cell_count, cell_start, member_out, status,
                  input ready);
  modport sink   (input valid, cell_out, cell_count, cell_start, member_out, status,
                  output ready);
endinterface

// ===== design/gclb_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on gclb_pkg for widths; used by gclb_dp for cell decomposition.
module gclb_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gclb_pkg::CELL_W-1:0]   dividend,
  input  logic [gclb_pkg::SIDE_W-1:0]   divisor,
  output logic                          done,
  output logic [gclb_pkg::CELL_W-1:0]   quotient,
  output logic [gclb_pkg::SIDE_W-1:0]   remainder
);

  localparam int CW = $clog2(gclb_pkg::CELL_W + 1);

  logic [gclb_pkg::CELL_W-1:0] quo_r, quo_nxt;
  logic [gclb_pkg::SIDE_W-1:0] rem_r, rem_nxt;
  logic [CW-1:0]               cnt_r;
  logic                        busy_r, done_r;
  logic [gclb_pkg::SIDE_W:0]   trial, diff;
  logic                        ge;

  // One restoring step
  always_comb begin
    trial   = {rem_r, quo_r[gclb_pkg::CELL_W-1]};
    ge      = trial >= {1'b0, divisor};
    diff    = trial - {1'b0, divisor};
    rem_nxt = ge ? diff[gclb_pkg::SIDE_W-1:0] : trial[gclb_pkg::SIDE_W-1:0];
    quo_nxt = {quo_r[gclb_pkg::CELL_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(gclb_pkg::CELL_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Payload shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== design/gclb_dp.sv =====
// Datapath: config registers, cell stores, point mapping, prefix sweep, result register.
// Depends on gclb_pkg and gclb_div; driven by commands from gclb_ctrl.
module gclb_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gclb_pkg::cmd_t                cmd,
  output gclb_pkg::sts_t                sts,
  input  logic                          cfg_we,
  input  logic [gclb_pkg::CFGI_W-1:0]   cfg_index,
  input  logic [gclb_pkg::CFGD_W-1:0]   cfg_data,
  input  logic [gclb_pkg::OP_W-1:0]     in_operation,
  input  logic [gclb_pkg::POS_W-1:0]    in_pos_x,
  input  logic [gclb_pkg::POS_W-1:0]    in_pos_y,
  input  logic [gclb_pkg::POS_W-1:0]    in_pos_z,
  input  logic [gclb_pkg::ID_W-1:0]     in_point_id,
  input  logic [gclb_pkg::CELL_W-1:0]   in_cell_select,
  input  logic [gclb_pkg::SLOT_W-1:0]   in_slot,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gclb_pkg::CELL_W-1:0]   out_cell_out,
  output logic [gclb_pkg::CNT_W-1:0]    out_cell_count,
  output logic [gclb_pkg::CNT_W-1:0]    out_cell_start,
  output logic [gclb_pkg::ID_W-1:0]     out_member_out,
  output logic [gclb_pkg::ST_W-1:0]     out_status
);

  localparam int SW = gclb_pkg::SIDE_W;
  localparam int AW = gclb_pkg::AX_W;
  localparam int CW = gclb_pkg::CELL_W;
  localparam int NW = gclb_pkg::CNT_W;

  // Clamp side to 1..MAX_SIDE
  function automatic logic [SW-1:0] clamp_side(input logic [SW-1:0] s);
    if (s == '0) return SW'(1);
    if (s > SW'(gclb_pkg::MAX_SIDE)) return SW'(gclb_pkg::MAX_SIDE);
    return s;
  endfunction

  // Saturate a scaled position to side-1
  function automatic logic [AW-1:0] sat_axis(input logic [gclb_pkg::SCALE_W-1:0] v,
                                             input logic [SW-1:0] s);
    logic [SW-1:0] m;
    m = s - SW'(1);
    if (v >= gclb_pkg::SCALE_W'(s)) return m[AW-1:0];
    return v[AW-1:0];
  endfunction

  // Periodic step: d=0 back, 1 stay, 2 forward
  function automatic logic [AW-1:0] wrap_axis(input logic [AW-1:0] a, input logic [1:0] d,
                                              input logic [SW-1:0] s);
    logic [SW-1:0] m, a1;
    m  = s - SW'(1);
    a1 = SW'(a) + SW'(1);
    if (d == 2'd0) return (a == '0) ? m[AW-1:0] : a - AW'(1);
    if (d == 2'd2) return (a1 >= s) ? '0 : a1[AW-1:0];
    return a;
  endfunction

  // Neighbour number to base-3 digits {di, dj, dk}
  function automatic logic [5:0] nbr_digits(input logic [gclb_pkg::NBR_W-1:0] n);
    logic [1:0] d2, d1, d0;
    logic [gclb_pkg::NBR_W-1:0] r;
    d2 = (n >= 5'd18) ? 2'd2 : ((n >= 5'd9) ? 2'd1 : 2'd0);
    r  = n - 5'(9 * d2);
    d1 = (r >= 5'd6) ? 2'd2 : ((r >= 5'd3) ? 2'd1 : 2'd0);
    r  = r - 5'(3 * d1);
    d0 = r[1:0];
    return {d2, d1, d0};
  endfunction

  // Config registers
  logic [SW-1:0]                   side_r;
  logic [gclb_pkg::SCALE_W-1:0]    scale_x_r, scale_y_r, scale_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r    <= SW'(gclb_pkg::MAX_SIDE);
      scale_x_r <= 32'd32;
      scale_y_r <= 32'd32;
      scale_z_r <= 32'd32;
    end else if (cfg_we) begin
      unique case (gclb_pkg::cfg_idx_t'(cfg_index))
        gclb_pkg::CFG_SIDE:    side_r    <= cfg_data[SW-1:0];
        gclb_pkg::CFG_SCALE_X: scale_x_r <= cfg_data;
        gclb_pkg::CFG_SCALE_Y: scale_y_r <= cfg_data;
        gclb_pkg::CFG_SCALE_Z: scale_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [SW-1:0]  side;
  logic [11:0]    side_sq;
  logic [17:0]    ncells;
  assign side    = clamp_side(side_r);
  assign side_sq = 12'(side) * 12'(side);
  assign ncells  = 18'(side_sq) * 18'(side);

  // Latched input word
  logic [gclb_pkg::OP_W-1:0]   op_r;
  logic [gclb_pkg::POS_W-1:0]  pos_x_r, pos_y_r, pos_z_r;
  logic [gclb_pkg::ID_W-1:0]   pid_r;
  logic [CW-1:0]               sel_r;
  logic [gclb_pkg::SLOT_W-1:0] slot_r;
  gclb_pkg::op_t               op;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r    <= in_operation;
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      pos_z_r <= in_pos_z;
      pid_r   <= in_point_id;
      sel_r   <= in_cell_select;
      slot_r  <= in_slot;
    end
  end
  assign op = gclb_pkg::op_t'(op_r);

  // Scale products, one multiplier per axis
  logic [gclb_pkg::PROD_W-1:0]  px, py, pz;
  logic [gclb_pkg::SCALE_W-1:0] prod_x_r, prod_y_r, prod_z_r;
  assign px = gclb_pkg::PROD_W'(pos_x_r) * gclb_pkg::PROD_W'(scale_x_r);
  assign py = gclb_pkg::PROD_W'(pos_y_r) * gclb_pkg::PROD_W'(scale_y_r);
  assign pz = gclb_pkg::PROD_W'(pos_z_r) * gclb_pkg::PROD_W'(scale_z_r);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_x_r <= px[gclb_pkg::PROD_W-1:gclb_pkg::POS_BITS];
      prod_y_r <= py[gclb_pkg::PROD_W-1:gclb_pkg::POS_BITS];
      prod_z_r <= pz[gclb_pkg::PROD_W-1:gclb_pkg::POS_BITS];
    end
  end

  // Divider for neighbour decomposition: pass 0 sel/side, pass 1 q1/side
  logic          div_done;
  logic [CW-1:0] div_quo, q1_r, div_dvd;
  logic [SW-1:0] div_rem;
  assign div_dvd = cmd.div_pass ? q1_r : sel_r;

  gclb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (side),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Axis indices
  logic [AW-1:0] ax_i_r, ax_j_r, ax_k_r;
  logic [5:0]    dig;
  assign dig = nbr_digits(slot_r[gclb_pkg::NBR_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.sat) begin
      ax_i_r <= sat_axis(prod_x_r, side);
      ax_j_r <= sat_axis(prod_y_r, side);
      ax_k_r <= sat_axis(prod_z_r, side);
    end else if (cmd.wrap) begin
      ax_i_r <= wrap_axis(ax_i_r, dig[5:4], side);
      ax_j_r <= wrap_axis(ax_j_r, dig[3:2], side);
      ax_k_r <= wrap_axis(ax_k_r, dig[1:0], side);
    end else if (div_done && !cmd.div_pass) begin
      q1_r   <= div_quo;
      ax_k_r <= div_rem[AW-1:0];
    end else if (div_done && cmd.div_pass) begin
      ax_i_r <= div_quo[AW-1:0];
      ax_j_r <= div_rem[AW-1:0];
    end
  end

  // Cell index (i*side + j)*side + k over two steps
  logic [gclb_pkg::IJ_W-1:0] ij_r;
  logic [CW-1:0]             cell_r;
  logic [10:0]               ij_full;
  logic [15:0]               cell_full;
  assign ij_full   = 11'(ax_i_r) * 11'(side) + 11'(ax_j_r);
  assign cell_full = 16'(ij_r) * 16'(side) + 16'(ax_k_r);

  always_ff @(posedge clk) begin
    if (cmd.cell1) ij_r   <= ij_full[gclb_pkg::IJ_W-1:0];
    if (cmd.cell2) cell_r <= cell_full[CW-1:0];
  end

  // Sweep pointer shared by clear and prefix
  logic [CW-1:0] swp_r;
  logic          sweep_last;
  assign sweep_last = (swp_r == CW'(gclb_pkg::NCELLS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swp_r <= '0;
    end else if (cmd.clr_step || cmd.pfx_wr) begin
      swp_r <= sweep_last ? '0 : swp_r + CW'(1);
    end
  end

  // Stores
  logic [NW-1:0]                count_mem  [gclb_pkg::NCELLS];
  logic [NW-1:0]                start_mem  [gclb_pkg::NCELLS];
  logic [NW-1:0]                fill_mem   [gclb_pkg::NCELLS];
  logic [gclb_pkg::ID_W-1:0]    member_mem [gclb_pkg::MAX_POINTS];

  logic [CW-1:0]             rd_cell;
  logic [NW-1:0]             cnt_rd_r, start_rd_r, fill_rd_r;
  logic [gclb_pkg::ID_W-1:0] mem_rd_r;

  always_comb begin
    if (cmd.pfx_rd) rd_cell = swp_r;
    else if (op == gclb_pkg::OP_READ_CELL) rd_cell = sel_r;
    else rd_cell = cell_r;
  end

  always_ff @(posedge clk) begin
    cnt_rd_r   <= count_mem[rd_cell];
    start_rd_r <= start_mem[rd_cell];
    fill_rd_r  <= fill_mem[rd_cell];
    mem_rd_r   <= member_mem[slot_r[gclb_pkg::MADDR_W-1:0]];
  end

  // Place check against the cell's end and the store size
  logic [NW:0]   place_lim;
  logic          place_ok;
  logic [NW-1:0] cnt_inc, fill_inc, acc_sum;
  assign place_lim = (NW+1)'(start_rd_r) + (NW+1)'(cnt_rd_r);
  assign place_ok  = ((NW+1)'(fill_rd_r) < place_lim) &&
                     (fill_rd_r < NW'(gclb_pkg::MAX_POINTS));
  assign cnt_inc   = cnt_rd_r + NW'(1);
  assign fill_inc  = fill_rd_r + NW'(1);

  logic cnt_wb, place_wb;
  assign cnt_wb   = cmd.mem_wb && (op == gclb_pkg::OP_COUNT);
  assign place_wb = cmd.mem_wb && (op == gclb_pkg::OP_PLACE) && place_ok;

  // Write ports
  logic          cnt_we, fill_we;
  logic [CW-1:0] cnt_wa, fill_wa;
  logic [NW-1:0] cnt_wd, fill_wd, acc_r;

  always_comb begin
    cnt_we  = cmd.clr_step || cnt_wb;
    cnt_wa  = cmd.clr_step ? swp_r : cell_r;
    cnt_wd  = cmd.clr_step ? '0 : cnt_inc;
    fill_we = cmd.pfx_wr || place_wb;
    fill_wa = cmd.pfx_wr ? swp_r : cell_r;
    fill_wd = cmd.pfx_wr ? acc_r : fill_inc;
  end

  always_ff @(posedge clk) begin
    if (cnt_we) count_mem[cnt_wa] <= cnt_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.pfx_wr) start_mem[swp_r] <= acc_r;
  end

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
  end

  always_ff @(posedge clk) begin
    if (place_wb) member_mem[fill_rd_r[gclb_pkg::MADDR_W-1:0]] <= pid_r;
  end

  // Points counted and prefix accumulator
  logic [NW-1:0] pts_r;
  assign acc_sum = acc_r + cnt_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r <= '0;
    end else if (cmd.clr_step) begin
      pts_r <= '0;
    end else if (cnt_wb) begin
      pts_r <= pts_r + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) acc_r <= '0;
    else if (cmd.pfx_wr) acc_r <= acc_sum;
  end

  // Result being built
  logic [CW-1:0]             res_cell_r;
  logic [NW-1:0]             res_count_r, res_start_r;
  logic [gclb_pkg::ID_W-1:0] res_member_r;
  gclb_pkg::status_t         res_status_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      res_cell_r   <= '0;
      res_count_r  <= '0;
      res_start_r  <= '0;
      res_member_r <= '0;
      res_status_r <= gclb_pkg::ST_OK;
    end else if (cmd.err_set) begin
      res_status_r <= cmd.err_code;
    end else if (cmd.pfx_wr && sweep_last) begin
      res_count_r <= acc_sum;
    end else if (cmd.mem_wb) begin
      case (op)
        gclb_pkg::OP_COUNT: begin
          res_cell_r  <= cell_r;
          res_count_r <= cnt_inc;
        end
        gclb_pkg::OP_PLACE: begin
          if (place_ok) begin
            res_cell_r   <= cell_r;
            res_count_r  <= cnt_rd_r;
            res_start_r  <= start_rd_r;
            res_member_r <= pid_r;
          end else begin
            res_status_r <= gclb_pkg::ST_FULL;
          end
        end
        gclb_pkg::OP_READ_CELL: begin
          res_cell_r  <= sel_r;
          res_count_r <= cnt_rd_r;
          res_start_r <= start_rd_r;
        end
        gclb_pkg::OP_READ_MEMBER: res_member_r <= mem_rd_r;
        gclb_pkg::OP_NEIGHBOUR:   res_cell_r   <= cell_r;
        default: ;
      endcase
    end
  end

  // Output register
  logic                      out_valid_r;
  logic [CW-1:0]             out_cell_r;
  logic [NW-1:0]             out_count_r, out_start_r;
  logic [gclb_pkg::ID_W-1:0] out_member_r;
  logic [gclb_pkg::ST_W-1:0] out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cell_r   <= res_cell_r;
      out_count_r  <= res_count_r;
      out_start_r  <= res_start_r;
      out_member_r <= res_member_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_out   = out_cell_r;
  assign out_cell_count = out_count_r;
  assign out_cell_start = out_start_r;
  assign out_member_out = out_member_r;
  assign out_status     = out_status_r;

  // Status to controller
  always_comb begin
    sts.op         = op;
    sts.store_full = pts_r >= NW'(gclb_pkg::MAX_POINTS);
    sts.sel_bad    = 18'(sel_r) >= ncells;
    sts.slot_bad   = slot_r > gclb_pkg::SLOT_W'(gclb_pkg::NBR_LAST);
    sts.sweep_last = sweep_last;
    sts.div_done   = div_done;
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule

// ===== design/gclb_ctrl.sv =====
// Controller state machine: sequences each operation over the datapath.
// Depends on gclb_pkg for the command and status structs.
module gclb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  gclb_pkg::sts_t sts,
  output gclb_pkg::cmd_t cmd
);

  typedef enum logic [17:0] {
    S_INIT    = 18'h00001,
    S_IDLE    = 18'h00002,
    S_DECODE  = 18'h00004,
    S_CLR     = 18'h00008,
    S_MUL     = 18'h00010,
    S_SAT     = 18'h00020,
    S_CELL1   = 18'h00040,
    S_CELL2   = 18'h00080,
    S_MRD     = 18'h00100,
    S_MWB     = 18'h00200,
    S_PRD     = 18'h00400,
    S_PWR     = 18'h00800,
    S_DIV1_GO = 18'h01000,
    S_DIV1    = 18'h02000,
    S_DIV2_GO = 18'h04000,
    S_DIV2    = 18'h08000,
    S_WRAP    = 18'h10000,
    S_RESP    = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op)
          gclb_pkg::OP_CLEAR:  state_nxt = S_CLR;
          gclb_pkg::OP_COUNT: begin
            if (sts.store_full) begin
              cmd.err_set  = 1'b1;
              cmd.err_code = gclb_pkg::ST_FULL;
              state_nxt    = S_RESP;
            end else begin
              state_nxt = S_MUL;
            end
          end
          gclb_pkg::OP_PREFIX:      state_nxt = S_PRD;
          gclb_pkg::OP_PLACE:       state_nxt = S_MUL;
          gclb_pkg::OP_READ_CELL: begin
            if (sts.sel_bad) begin
              cmd.err_set  = 1'b1;
              cmd.err_code = gclb_pkg::ST_RANGE;
              state_nxt    = S_RESP;
            end else begin
              state_nxt = S_MRD;
            end
          end
          gclb_pkg::OP_READ_MEMBER: state_nxt = S_MRD;
          gclb_pkg::OP_NEIGHBOUR: begin
            if (sts.sel_bad || sts.slot_bad) begin
              cmd.err_set  = 1'b1;
              cmd.err_code = gclb_pkg::ST_RANGE;
              state_nxt    = S_RESP;
            end else begin
              state_nxt = S_DIV1_GO;
            end
          end
          default: begin
            cmd.err_set  = 1'b1;
            cmd.err_code = gclb_pkg::ST_RANGE;
            state_nxt    = S_RESP;
          end
        endcase
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.sweep_last) state_nxt = S_RESP;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_CELL1;
      end
      S_CELL1: begin
        cmd.cell1 = 1'b1;
        state_nxt = S_CELL2;
      end
      S_CELL2: begin
        cmd.cell2 = 1'b1;
        state_nxt = (sts.op == gclb_pkg::OP_NEIGHBOUR) ? S_MWB : S_MRD;
      end
      S_MRD: state_nxt = S_MWB;
      S_MWB: begin
        cmd.mem_wb = 1'b1;
        state_nxt  = S_RESP;
      end
      S_PRD: begin
        cmd.pfx_rd = 1'b1;
        state_nxt  = S_PWR;
      end
      S_PWR: begin
        cmd.pfx_wr = 1'b1;
        state_nxt  = sts.sweep_last ? S_RESP : S_PRD;
      end
      S_DIV1_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV1;
      end
      S_DIV1: begin
        if (sts.div_done) state_nxt = S_DIV2_GO;
      end
      S_DIV2_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_pass  = 1'b1;
        state_nxt     = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_pass = 1'b1;
        if (sts.div_done) state_nxt = S_WRAP;
      end
      S_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = S_CELL1;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

// ===== design/grid_cell_list_binning.sv =====
// Grid cell-list binning top level: word channels, config port, controller and datapath.
// Depends on gclb_pkg, gclb_if, gclb_ctrl, gclb_dp (and gclb_div below it).
//
// Bins 3D points into a cubic grid of up to 32x32x32 cells by counting sort.
// One word is processed at a time; the controller steps it through the
// datapath and the result sits in an output register while the next word is
// taken. After reset the block zeroes the cell counts (one cell per cycle)
// before it accepts its first word; config writes are taken during that pass.
// The steps per word, from acceptance to result valid: clear repeats the
// same one-cell-per-cycle sweep of the count memory, prefix reads then writes
// every cell, count and place point use three scale multipliers, two index
// steps, then a read-modify-write of the cell stores, read cell and read
// member use one registered memory read, neighbour runs two passes of the
// bit-serial divider that splits the cell index, then wraps and rebuilds it,
// and an error result is answered straight from decode.
module grid_cell_list_binning (
  input  logic                          clk,
  input  logic                          rst_n,
  gclb_in_if.sink                       in_if,
  gclb_out_if.source                    out_if,
  input  logic                          cfg_we,
  input  logic [gclb_pkg::CFGI_W-1:0]   cfg_index,
  input  logic [gclb_pkg::CFGD_W-1:0]   cfg_data
);

  gclb_pkg::cmd_t cmd;
  gclb_pkg::sts_t sts;

  // Sequencer
  gclb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Stores and arithmetic
  gclb_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_operation   (in_if.operation),
    .in_pos_x       (in_if.pos_x),
    .in_pos_y       (in_if.pos_y),
    .in_pos_z       (in_if.pos_z),
    .in_point_id    (in_if.point_id),
    .in_cell_select (in_if.cell_select),
    .in_slot        (in_if.slot),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_cell_out   (out_if.cell_out),
    .out_cell_count (out_if.cell_count),
    .out_cell_start (out_if.cell_start),
    .out_member_out (out_if.member_out),
    .out_status     (out_if.status)
  );

endmodule

// ===== tb/sv/gclb_bin_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the grid cell-list binning block: watches both word
// channels and the config port, predicts every result and compares it.
// Depends on gclb_pkg and the gclb_in_if / gclb_out_if interfaces.
module gclb_bin_checker
  import gclb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  gclb_in_if                in_if,
  gclb_out_if               out_if,
  input  logic              cfg_we,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFGD_W-1:0] cfg_data,
  output int                pending,
  output int                errors
);

  typedef struct packed {
    logic [CELL_W-1:0] cell_idx;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  start;
    logic [ID_W-1:0]   member;
    status_t           status;
  } bin_result_t;

  // Shadow configuration and grid stores
  logic [SIDE_W-1:0]  side_reg;
  logic [SCALE_W-1:0] scale_reg [3];
  logic [CNT_W-1:0]   cell_counts [NCELLS];
  logic [CNT_W-1:0]   cell_fill   [NCELLS];
  logic [CNT_W-1:0]   cell_starts [NCELLS];
  logic [ID_W-1:0]    member_ids  [MAX_POINTS];
  logic [CNT_W-1:0]   points_seen;

  bin_result_t expected_bins [$];
  bin_result_t want;
  int          err_cnt = 0;

  function automatic int unsigned grid_side_eff();
    int unsigned s;
    s = side_reg;
    if (s < 1) s = 1;
    if (s > MAX_SIDE) s = MAX_SIDE;
    return s;
  endfunction

  // Position times scale, top bits kept, saturated to the last cell
  function automatic int unsigned axis_cell(logic [POS_W-1:0] p, logic [SCALE_W-1:0] sc,
                                            int unsigned side);
    longint unsigned v;
    v = (longint'(p) * longint'(sc)) >> POS_BITS;
    if (v >= side) v = side - 1;
    return int'(v);
  endfunction

  function automatic int unsigned wrap_step(int unsigned a, int d, int unsigned side);
    if (d < 0) return (a == 0) ? side - 1 : a - 1;
    if (d > 0) return (a + 1 >= side) ? 0 : a + 1;
    return a;
  endfunction

  function automatic bin_result_t predict_bin(op_t op, logic [POS_W-1:0] px,
                                              logic [POS_W-1:0] py, logic [POS_W-1:0] pz,
                                              logic [ID_W-1:0] pid, logic [CELL_W-1:0] sel,
                                              logic [SLOT_W-1:0] slot);
    bin_result_t r;
    int unsigned side, ncells, c, t, i, j, k;
    r = '0;
    r.status = ST_OK;
    side = grid_side_eff();
    ncells = side * side * side;
    c = (axis_cell(px, scale_reg[0], side) * side + axis_cell(py, scale_reg[1], side)) * side
        + axis_cell(pz, scale_reg[2], side);
    case (op)
      OP_CLEAR: begin
        foreach (cell_counts[n]) cell_counts[n] = '0;
        points_seen = '0;
      end
      OP_COUNT: begin
        if (points_seen >= MAX_POINTS) begin
          r.status = ST_FULL;
        end else begin
          cell_counts[c] = cell_counts[c] + 1'b1;
          points_seen = points_seen + 1'b1;
          r.cell_idx = CELL_W'(c);
          r.count = cell_counts[c];
        end
      end
      OP_PREFIX: begin
        t = 0;
        for (int n = 0; n < NCELLS; n++) begin
          cell_starts[n] = CNT_W'(t);
          cell_fill[n] = CNT_W'(t);
          t += cell_counts[n];
        end
        r.count = CNT_W'(t);
      end
      OP_PLACE: begin
        t = cell_fill[c];
        if (t >= cell_starts[c] + cell_counts[c] || t >= MAX_POINTS) begin
          r.status = ST_FULL;
        end else begin
          member_ids[t] = pid;
          cell_fill[c] = CNT_W'(t + 1);
          r.cell_idx = CELL_W'(c);
          r.count = cell_counts[c];
          r.start = cell_starts[c];
          r.member = pid;
        end
      end
      OP_READ_CELL: begin
        if (sel >= ncells) begin
          r.status = ST_RANGE;
        end else begin
          r.cell_idx = sel;
          r.count = cell_counts[sel];
          r.start = cell_starts[sel];
        end
      end
      OP_READ_MEMBER: begin
        if (slot >= MAX_POINTS) r.status = ST_RANGE;
        else r.member = member_ids[slot];
      end
      OP_NEIGHBOUR: begin
        if (sel >= ncells || slot > NBR_LAST) begin
          r.status = ST_RANGE;
        end else begin
          i = wrap_step(sel / (side * side), int'(slot / 9) - 1, side);
          j = wrap_step((sel / side) % side, int'((slot / 3) % 3) - 1, side);
          k = wrap_step(sel % side, int'(slot % 3) - 1, side);
          r.cell_idx = CELL_W'((i * side + j) * side + k);
        end
      end
      default: r.status = ST_RANGE;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, got_v);
    end
  endtask

  // Monitor: results first, then new words
  always @(posedge clk) begin
    if (!rst_n) begin
      side_reg = MAX_SIDE;
      foreach (scale_reg[n]) scale_reg[n] = 32;
      foreach (cell_counts[n]) cell_counts[n] = '0;
      points_seen = '0;
      expected_bins.delete();
      pending <= 0;
      errors <= err_cnt;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_bins.size() == 0) begin
          err_cnt++;
          $display("%0t: result word with nothing expected, cell %0d status %0d", $time,
                   out_if.cell_out, out_if.status);
        end else begin
          want = expected_bins.pop_front();
          check_field("cell_out", want.cell_idx, out_if.cell_out);
          check_field("cell_count", want.count, out_if.cell_count);
          check_field("cell_start", want.start, out_if.cell_start);
          check_field("member_out", want.member, out_if.member_out);
          check_field("status", want.status, out_if.status);
        end
      end
      if (in_if.valid && in_if.ready)
        expected_bins = {expected_bins,
                         predict_bin(op_t'(in_if.operation), in_if.pos_x, in_if.pos_y,
                                     in_if.pos_z, in_if.point_id, in_if.cell_select,
                                     in_if.slot)};
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SIDE:    side_reg = cfg_data[SIDE_W-1:0];
          CFG_SCALE_X: scale_reg[0] = cfg_data;
          CFG_SCALE_Y: scale_reg[1] = cfg_data;
          CFG_SCALE_Z: scale_reg[2] = cfg_data;
          default: ;
        endcase
      end
      pending <= expected_bins.size();
      errors <= err_cnt;
    end
  end

endmodule

// ===== tb/sv/grid_cell_list_binning_tb.sv =====
`timescale 1ns / 100ps
// Top of the binning testbench: clock, reset, config writes, word stimulus
// and verdict. Depends on gclb_pkg, the word interfaces, gclb_bin_checker
// and the grid_cell_list_binning block.
module grid_cell_list_binning_tb;
  import gclb_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  typedef struct {
    op_t               op;
    logic [POS_W-1:0]  px, py, pz;
    logic [ID_W-1:0]   pid;
    logic [CELL_W-1:0] sel;
    logic [SLOT_W-1:0] slot;
  } bin_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we;
  logic [CFGI_W-1:0] cfg_index;
  logic [CFGD_W-1:0] cfg_data;
  int                pending, errors;
  bit                quiet = 1'b0;
  int                stall_left = 0;
  int                idle_cycles = 0;
  int unsigned       cur_side = MAX_SIDE;
  int unsigned       written_hi = 0;

  gclb_in_if  in_if ();
  gclb_out_if out_if ();

  grid_cell_list_binning u_top (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gclb_bin_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: random stall bursts that hold ready low
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("grid_cell_list_binning_tb failed");
      $finish;
    end
  end

  function automatic bin_word_t rand_word(op_t op);
    bin_word_t w;
    w.op = op;
    w.px = POS_W'($urandom);
    w.py = POS_W'($urandom);
    w.pz = POS_W'($urandom);
    w.pid = ID_W'($urandom);
    w.sel = CELL_W'($urandom);
    w.slot = SLOT_W'($urandom);
    return w;
  endfunction

  task automatic send_word(bin_word_t w);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= w.op;
    in_if.pos_x <= w.px;
    in_if.pos_y <= w.py;
    in_if.pos_z <= w.pz;
    in_if.point_id <= w.pid;
    in_if.cell_select <= w.sel;
    in_if.slot <= w.slot;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Register writes, one per cycle; only called with no word in flight
  task automatic set_grid(logic [SIDE_W-1:0] side, logic [31:0] sx, logic [31:0] sy,
                          logic [31:0] sz);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SIDE;    cfg_data <= side; @(posedge clk);
    cfg_index <= CFG_SCALE_X; cfg_data <= sx;   @(posedge clk);
    cfg_index <= CFG_SCALE_Y; cfg_data <= sy;   @(posedge clk);
    cfg_index <= CFG_SCALE_Z; cfg_data <= sz;   @(posedge clk);
    cfg_we <= 1'b0;
    cur_side = (side == 0) ? 1 : (side > MAX_SIDE) ? MAX_SIDE : side;
  endtask

  task automatic send_op(op_t op, logic [CELL_W-1:0] sel, logic [SLOT_W-1:0] slot);
    bin_word_t w;
    w = rand_word(op);
    w.sel = sel;
    w.slot = slot;
    send_word(w);
  endtask

  task automatic send_point(op_t op, logic [POS_W-1:0] p, logic [ID_W-1:0] pid);
    bin_word_t w;
    w = rand_word(op);
    w.px = p;
    w.py = p;
    w.pz = p;
    w.pid = pid;
    send_word(w);
  endtask

  // One counting-sort pass: clear, count, prefix, place everything, then reads
  task automatic run_pass(int n_pts, bit hold_once);
    bin_word_t pts[$];
    bin_word_t w, tmp;
    int unsigned ncells, pick;
    ncells = cur_side * cur_side * cur_side;
    send_op(OP_CLEAR, 0, 0);
    for (int n = 0; n < n_pts; n++) begin
      w = rand_word(OP_COUNT);
      pts = {pts, w};
      send_word(w);
      if ($urandom_range(0, 19) == 0)
        send_op(OP_NEIGHBOUR, CELL_W'($urandom_range(0, ncells - 1)),
                SLOT_W'($urandom_range(0, NBR_LAST)));
    end
    send_op(OP_PREFIX, CELL_W'($urandom), SLOT_W'($urandom));
    for (int n = 0; n < pts.size(); n++) begin
      pick = $urandom_range(n, pts.size() - 1);
      tmp = pts[n];
      pts[n] = pts[pick];
      pts[pick] = tmp;
    end
    foreach (pts[n]) begin
      w = pts[n];
      w.op = OP_PLACE;
      w.pid = ID_W'($urandom);
      send_word(w);
      if ($urandom_range(0, 9) == 0) send_word(rand_word(OP_PLACE));
      if (hold_once && n == pts.size() / 2) wait_drained();
    end
    if (n_pts > written_hi) written_hi = n_pts;
    for (int n = 0; n < n_pts; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)
        send_op(OP_READ_CELL, (pick < 30) ? CELL_W'($urandom_range(0, ncells - 1))
                                          : CELL_W'($urandom), 0);
      else if (pick < 60)
        send_op(OP_READ_MEMBER, 0, SLOT_W'($urandom_range(0, written_hi - 1)));
      else if (pick < 90)
        send_op(OP_NEIGHBOUR, (pick < 87) ? CELL_W'($urandom_range(0, ncells - 1))
                                          : CELL_W'($urandom),
                (pick < 84) ? SLOT_W'($urandom_range(0, NBR_LAST)) : SLOT_W'($urandom));
      else if (pick < 96)
        send_word(rand_word(OP_COUNT));
      else
        send_word(rand_word(OP_UNKNOWN));
    end
    wait_drained();
  endtask

  initial begin
    int unsigned s;
    in_if.valid = 1'b0;
    in_if.operation = OP_CLEAR;
    in_if.pos_x = '0;
    in_if.pos_y = '0;
    in_if.pos_z = '0;
    in_if.point_id = '0;
    in_if.cell_select = '0;
    in_if.slot = '0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SIDE;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a 4x4x4 grid, corner points, full cell, every read, range errors and an unknown op
    set_grid(4, 4, 4, 4);
    send_op(OP_CLEAR, 0, 0);
    send_point(OP_COUNT, '0, 0);
    send_point(OP_COUNT, '1, 0);
    send_point(OP_COUNT, '1, 0);
    send_op(OP_PREFIX, 0, 0);
    send_point(OP_PLACE, '0, '1);
    send_point(OP_PLACE, '1, 16'h0000);
    send_point(OP_PLACE, '1, 16'h5a5a);
    send_point(OP_PLACE, '1, 16'h1234);      // cell already full
    written_hi = 3;
    send_op(OP_READ_CELL, 0, 0);
    send_op(OP_READ_CELL, 63, 0);
    send_op(OP_READ_CELL, 64, 0);            // just past the grid
    send_op(OP_READ_CELL, '1, 0);
    send_op(OP_READ_MEMBER, 0, 0);
    send_op(OP_READ_MEMBER, 0, 1);
    send_op(OP_READ_MEMBER, 0, 2);
    send_op(OP_NEIGHBOUR, 0, 0);
    send_op(OP_NEIGHBOUR, 63, NBR_LAST);
    send_op(OP_NEIGHBOUR, 21, 13);
    send_op(OP_NEIGHBOUR, 5, NBR_LAST + 1);  // bad neighbour number
    send_op(OP_NEIGHBOUR, 5, '1);
    send_op(OP_NEIGHBOUR, 64, 0);            // bad cell
    send_op(OP_UNKNOWN, 0, 0);
    wait_drained();

    // Random passes over several grid settings, extremes included
    set_grid(32, 32, 32, 32);
    run_pass(100, 1'b1);
    set_grid(0, $urandom, $urandom, $urandom);
    run_pass(50, 1'b0);
    set_grid(63, '1, '1, '1);
    quiet = 1'b1;
    run_pass(50, 1'b0);
    quiet = 1'b0;
    s = $urandom_range(1, 63);
    set_grid(SIDE_W'(s), $urandom_range(0, 3 * s), $urandom_range(0, 3 * s),
             $urandom_range(0, 3 * s));
    run_pass(150, 1'b0);

    // One crowded cell: every point lands in cell 0, then extra places find it full
    quiet = 1'b1;
    set_grid(2, 0, 0, 0);
    send_op(OP_CLEAR, 0, 0);
    for (int n = 0; n < 20; n++) send_word(rand_word(OP_COUNT));
    send_op(OP_PREFIX, 0, 0);
    for (int n = 0; n < 22; n++) send_word(rand_word(OP_PLACE));
    send_op(OP_READ_CELL, 0, 0);
    send_op(OP_CLEAR, 0, 0);
    wait_drained();

    // Last part without any idling
    set_grid(5, 5, 6, 4);
    run_pass(100, 1'b0);

    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("grid_cell_list_binning_tb passed");
    else $display("grid_cell_list_binning_tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/gclb_pkg.sv
design/gclb_if.sv
design/gclb_div.sv
design/gclb_dp.sv
design/gclb_ctrl.sv
design/grid_cell_list_binning.sv
tb/sv/gclb_bin_checker.sv
tb/sv/grid_cell_list_binning_tb.sv
